// ===== rtl/base64_stream_decoder_defines.svh =====
// Assertion macros shared by the base64 stream decoder RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef BASE64_STREAM_DECODER_DEFINES_SVH
`define BASE64_STREAM_DECODER_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define B64SD_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define B64SD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/b64sd_pkg.sv =====
// Package for the base64 stream decoder: word types, run buffer load type,
// character codes and the character-to-sextet map. Depends on nothing.
package b64sd_pkg;

    localparam int unsigned RunDepth = 3;

    localparam logic [7:0] ChUpperA = 8'h41;
    localparam logic [7:0] ChUpperZ = 8'h5a;
    localparam logic [7:0] ChLowerA = 8'h61;
    localparam logic [7:0] ChLowerZ = 8'h7a;
    localparam logic [7:0] ChDigit0 = 8'h30;
    localparam logic [7:0] ChDigit9 = 8'h39;
    localparam logic [7:0] ChPlus   = 8'h2b;
    localparam logic [7:0] ChMinus  = 8'h2d;
    localparam logic [7:0] ChSlash  = 8'h2f;
    localparam logic [7:0] ChUnder  = 8'h5f;

    localparam logic [5:0] LowerBase  = 6'd26;
    localparam logic [5:0] DigitBase  = 6'd52;
    localparam logic [5:0] Sextet62   = 6'd62;
    localparam logic [5:0] Sextet63   = 6'd63;
    localparam logic [5:0] SextetOnes = 6'h3f;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_string;
    } b64sd_in_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_of_run;
        logic       string_done;
    } b64sd_out_t;

    typedef struct packed {
        logic                     load;
        logic [1:0]               count;
        b64sd_out_t [RunDepth-1:0] items;
    } b64sd_run_t;

    // Result bit 6 flags an invalid character; bits 5:0 carry the sextet.
    function automatic logic [6:0] b64sd_map_char(input logic [7:0] c);
        logic [7:0] d;
        d = '0;
        priority if (c >= ChUpperA && c <= ChUpperZ) begin
            d = c - ChUpperA;
            return {1'b0, d[5:0]};
        end else if (c >= ChLowerA && c <= ChLowerZ) begin
            d = c - ChLowerA;
            return {1'b0, d[5:0] + LowerBase};
        end else if (c >= ChDigit0 && c <= ChDigit9) begin
            d = c - ChDigit0;
            return {1'b0, d[5:0] + DigitBase};
        end else if (c == ChPlus || c == ChMinus) begin
            return {1'b0, Sextet62};
        end else if (c == ChSlash || c == ChUnder) begin
            return {1'b0, Sextet63};
        end else begin
            return {1'b1, SextetOnes};
        end
    endfunction

endpackage

// ===== rtl/base64_stream_decoder.sv =====
// Base64 stream decoder: one character word in, decoded byte words out.
// Depends on b64sd_pkg and b64sd_run_buffer.
//
// Use: s_data carries one character and its end-of-string flag per word on a
// valid/ready channel. m_data carries decoded bytes, each with last_of_run
// (final byte caused by one character) and string_done (the run that closed
// the final group of a string). A group of four characters, or a shorter one
// cut by end_of_string, yields up to three bytes; byte k appears only when
// character k+1 of the group is valid. Invalid characters count as all ones.
// A completing character is registered in the input register; its run is loaded
// into the run buffer once it is free, which then offers the run's first byte.
// Throughput: one character per cycle while s_ready is high; a run drains
// at one byte per cycle while m_ready is high, and the buffer takes a new run
// only when empty or in the cycle its last byte leaves, so a three-byte run
// followed at full rate by a two-character string stalls its second character.
// Stall: while m_ready is low the run buffer holds; characters that only join
// a group, or close one with no bytes, still enter, and a completing character
// with bytes waits in the input register with s_ready low until the buffer can
// take its run.
// Reset: aresetn (synchronous, active low) empties both registers and starts a
// new group.

module base64_stream_decoder
    import b64sd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  b64sd_in_t  s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output b64sd_out_t m_data
);

    logic                 in_valid_reg, in_valid_next;
    b64sd_in_t            in_data_reg;
    logic [1:0]           group_position_reg, group_position_next;
    logic [2:0][5:0]      held_sextets_reg, held_sextets_next;
    logic [2:0]           held_invalid_reg, held_invalid_next;

    logic [6:0]           mapped;
    logic                 complete;
    logic [3:0][5:0]      sx;
    logic [3:0]           sv;
    logic [2:0][7:0]      bytes;
    b64sd_run_t           run;
    logic [1:0]           idx;
    logic                 run_free;
    logic                 take;

    assign mapped   = b64sd_map_char(in_data_reg.char_code);
    assign complete = in_data_reg.end_of_string || (group_position_reg == 2'd3);

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (2'(i) < group_position_reg && i < 3) begin
                sx[i] = held_sextets_reg[i[1:0]];
                sv[i] = !held_invalid_reg[i[1:0]];
            end else if (2'(i) == group_position_reg) begin
                sx[i] = mapped[5:0];
                sv[i] = !mapped[6];
            end else begin
                sx[i] = SextetOnes;
                sv[i] = 1'b0;
            end
        end
    end

    assign bytes[0] = {sx[0], sx[1][5:4]};
    assign bytes[1] = {sx[1][3:0], sx[2][5:2]};
    assign bytes[2] = {sx[2][1:0], sx[3]};

    always_comb begin
        idx       = 2'd0;
        run.items = '0;
        for (int i = 0; i < 3; i++) begin
            if (sv[i+1]) begin
                run.items[idx] = '{data_byte: bytes[i], last_of_run: 1'b0,
                                   string_done: in_data_reg.end_of_string};
                idx = idx + 2'd1;
            end
        end
        if (idx != 2'd0) begin
            run.items[idx - 2'd1].last_of_run = 1'b1;
        end
        run.count = idx;
        run.load  = in_valid_reg && complete && idx != 2'd0 && run_free;
    end

    assign take     = in_valid_reg && (!complete || idx == 2'd0 || run_free);
    assign s_ready  = !in_valid_reg || take;

    always_comb begin
        in_valid_next       = in_valid_reg;
        group_position_next = group_position_reg;
        held_sextets_next   = held_sextets_reg;
        held_invalid_next   = held_invalid_reg;
        if (take) begin
            in_valid_next = 1'b0;
            if (complete) begin
                // drop held group
                group_position_next = 2'd0;
                held_sextets_next   = '0;
                held_invalid_next   = '0;
            end else begin
                held_sextets_next[group_position_reg] = mapped[5:0];
                held_invalid_next[group_position_reg] = mapped[6];
                group_position_next = group_position_reg + 2'd1;
            end
        end
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg       <= 1'b0;
            group_position_reg <= 2'd0;
            held_sextets_reg   <= '0;
            held_invalid_reg   <= '0;
        end else begin
            in_valid_reg       <= in_valid_next;
            group_position_reg <= group_position_next;
            held_sextets_reg   <= held_sextets_next;
            held_invalid_reg   <= held_invalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    b64sd_run_buffer u_run_buffer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .run_in   (run),
        .run_free (run_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

// ===== rtl/b64sd_run_buffer.sv =====
// Output run buffer: holds up to three bytes of a finished group and presents them
// one per cycle as m_ready allows. Depends on b64sd_pkg and the defines header.
`include "base64_stream_decoder_defines.svh"

module b64sd_run_buffer
    import b64sd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  b64sd_run_t run_in,
    output logic       run_free,
    output logic       m_valid,
    input  logic       m_ready,
    output b64sd_out_t m_data
);

    b64sd_out_t [RunDepth-1:0] entries_reg, entries_next;
    logic [1:0]                count_reg, count_next;
    logic                      pop;

    assign pop      = m_valid && m_ready;
    assign m_valid  = (count_reg != 2'd0);
    assign m_data   = entries_reg[0];
    assign run_free = (count_reg == 2'd0) || (count_reg == 2'd1 && pop);

    always_comb begin
        entries_next = entries_reg;
        count_next   = count_reg;
        if (pop) begin
            // advance
            entries_next[0] = entries_reg[1];
            entries_next[1] = entries_reg[2];
            count_next      = count_reg - 2'd1;
        end
        if (run_in.load) begin
            entries_next = run_in.items;
            count_next   = run_in.count;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        entries_reg <= entries_next;
    end

    `B64SD_ASSERT_SAME(a_load_when_free, aclk, aresetn, run_in.load, run_free,
        "run buffer loaded while still holding bytes")
    `B64SD_ASSERT_SAME(a_load_nonempty, aclk, aresetn, run_in.load, run_in.count != 2'd0,
        "run buffer loaded with an empty run")
    `B64SD_ASSERT_SAME(a_tail_is_last, aclk, aresetn, count_reg == 2'd1,
        m_data.last_of_run, "final byte of a run lacks its last mark")
    `B64SD_ASSERT_NEXT(a_pop_drains, aclk, aresetn, pop && !run_in.load && count_reg == 2'd1,
        !m_valid, "run buffer still valid after its final byte left")

endmodule
